// ===== rtl/grsm_pkg.sv =====
// Package for the Golomb-Rice coded set match block.
// Holds the sequencer states, field codes, register indexes and reset values.
// No dependencies.
package grsm_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_BIT,
        ST_SUM,
        ST_CMP,
        ST_EMIT
    } state_t;

    // Values of the op field.
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Outcome codes.
    localparam logic [1:0] OUT_FOUND     = 2'd0;
    localparam logic [1:0] OUT_PASSED    = 2'd1;
    localparam logic [1:0] OUT_EXHAUSTED = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_RICE_BITS = 1'b0;
    localparam logic REG_FP_RATE   = 1'b1;

    // Register widths and reset values.
    localparam int          RICE_W        = 6;
    localparam int          RATE_W        = 32;
    localparam logic [5:0]  RICE_RESET    = 6'd19;
    localparam logic [31:0] FP_RATE_RESET = 32'd784931;

    // Widest remainder a code may carry.
    localparam logic [5:0] MAX_RICE = 6'd32;

    // Multiplier passes at start: the bound, then four partial products.
    localparam int         MUL_STEPS = 5;
    localparam logic [2:0] MUL_LAST  = 3'(MUL_STEPS - 1);

endpackage

// ===== rtl/golomb_rice_set_member_match.sv =====
// Top level of the Golomb-Rice coded set match block.
// Single module; uses grsm_pkg for states, codes and register constants.
//
// A start word (op = 0) carries the 64-bit hash of the target and the number of
// coded elements. The block forms bound = fp_rate * set_count and maps the hash
// into [0, bound) as the upper 64 bits of hash * bound, using one shared 32x32
// multiplier: five passes (the bound, then four partial products), each a
// multiply step and then an accumulate step; no new word is taken until the
// last pass is done. A set count of zero skips the multiplier and answers at
// once with outcome "set exhausted". Data words (op = 1) bring the coded set
// one byte at a time, MSB first, and a bit-serial decoder consumes one code
// bit per cycle, pausing after each element that completes to add the delta
// and then compare; no new word is taken while a byte is being decoded. The
// pace is set by the single-bit decoder step and by the shared multiplier at
// start. Once a decision is reached, the rest of the byte is dropped, the
// query closes and one result word is issued; data words that arrive while
// no query is open are taken and ignored. The result sits in an output
// register, so new input can be taken while it waits, but a further result
// holds in the emit state until the output register is free.
// Configuration writes are expected only while the block is idle; rice_bits is
// sampled when a code's remainder begins and values above 32 act as 32.
module golomb_rice_set_member_match (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [63:0] s_target_hash,
    input  logic [31:0] s_set_count,
    input  logic [7:0]  s_data_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_matched,
    output logic [1:0]  m_outcome,
    output logic [31:0] m_elements_decoded
);

    // Control state (reset).
    grsm_pkg::state_t state_reg, state_next;
    logic        query_active_reg, query_active_next;
    logic        in_rem_reg, in_rem_next;
    logic [2:0]  step_reg, step_next;
    logic        m_valid_reg, m_valid_next;
    logic [5:0]  rice_bits_reg;
    logic [31:0] fp_rate_reg;

    // Datapath state (no reset needed).
    logic [63:0]  hash_reg, hash_next;
    logic [63:0]  bound_reg, bound_next;
    logic [63:0]  prod_reg, prod_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  target_reg, target_next;
    logic [63:0]  running_reg, running_next;
    logic [63:0]  quot_reg, quot_next;
    logic [31:0]  rem_acc_reg, rem_acc_next;
    logic [5:0]   rem_left_reg, rem_left_next;
    logic [5:0]   code_w_reg, code_w_next;
    logic [31:0]  elems_left_reg, elems_left_next;
    logic [31:0]  decoded_reg, decoded_next;
    logic [7:0]   byte_reg, byte_next;
    logic [2:0]   bit_idx_reg, bit_idx_next;
    logic         last_bit_reg, last_bit_next;
    logic [1:0]   pend_outcome_reg, pend_outcome_next;
    logic         m_matched_reg, m_matched_next;
    logic [1:0]   m_outcome_reg, m_outcome_next;
    logic [31:0]  m_decoded_reg, m_decoded_next;

    // Shared multiplier operands and shift for the accumulate pass.
    logic [31:0] mul_a, mul_b;
    logic [6:0]  acc_shift;
    logic        cur_bit;
    logic        finish;
    logic [5:0]  rice_clamped;
    logic        s_fire;

    assign s_ready = (state_reg == grsm_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign m_valid            = m_valid_reg;
    assign m_matched          = m_matched_reg;
    assign m_outcome          = m_outcome_reg;
    assign m_elements_decoded = m_decoded_reg;

    assign rice_clamped = (rice_bits_reg > grsm_pkg::MAX_RICE) ? grsm_pkg::MAX_RICE
                                                                : rice_bits_reg;
    assign cur_bit = byte_reg[bit_idx_reg];

    // Operand selection for each pass of the multiplier.
    always_comb begin
        case (step_reg)
            3'd0: begin
                mul_a     = fp_rate_reg;
                mul_b     = elems_left_reg;
                acc_shift = 7'd0;
            end
            3'd1: begin
                mul_a     = hash_reg[31:0];
                mul_b     = bound_reg[31:0];
                acc_shift = 7'd0;
            end
            3'd2: begin
                mul_a     = hash_reg[31:0];
                mul_b     = bound_reg[63:32];
                acc_shift = 7'd32;
            end
            3'd3: begin
                mul_a     = hash_reg[63:32];
                mul_b     = bound_reg[31:0];
                acc_shift = 7'd32;
            end
            default: begin
                mul_a     = hash_reg[63:32];
                mul_b     = bound_reg[63:32];
                acc_shift = 7'd64;
            end
        endcase
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        state_next        = state_reg;
        query_active_next = query_active_reg;
        in_rem_next       = in_rem_reg;
        step_next         = step_reg;
        m_valid_next      = m_valid_reg;
        hash_next         = hash_reg;
        bound_next        = bound_reg;
        prod_next         = prod_reg;
        acc_next          = acc_reg;
        target_next       = target_reg;
        running_next      = running_reg;
        quot_next         = quot_reg;
        rem_acc_next      = rem_acc_reg;
        rem_left_next     = rem_left_reg;
        code_w_next       = code_w_reg;
        elems_left_next   = elems_left_reg;
        decoded_next      = decoded_reg;
        byte_next         = byte_reg;
        bit_idx_next      = bit_idx_reg;
        last_bit_next     = last_bit_reg;
        pend_outcome_next = pend_outcome_reg;
        m_matched_next    = m_matched_reg;
        m_outcome_next    = m_outcome_reg;
        m_decoded_next    = m_decoded_reg;
        finish            = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            grsm_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_op == grsm_pkg::OP_START) begin
                        // A new query drops whatever was running.
                        hash_next         = s_target_hash;
                        elems_left_next   = s_set_count;
                        running_next      = '0;
                        quot_next         = '0;
                        rem_acc_next      = '0;
                        rem_left_next     = '0;
                        code_w_next       = '0;
                        in_rem_next       = 1'b0;
                        decoded_next      = '0;
                        acc_next          = '0;
                        step_next         = '0;
                        query_active_next = 1'b1;
                        if (s_set_count == 32'd0) begin
                            query_active_next = 1'b0;
                            pend_outcome_next = grsm_pkg::OUT_EXHAUSTED;
                            state_next        = grsm_pkg::ST_EMIT;
                        end else begin
                            state_next = grsm_pkg::ST_MUL;
                        end
                    end else if (query_active_reg) begin
                        byte_next    = s_data_byte;
                        bit_idx_next = 3'd7;
                        state_next   = grsm_pkg::ST_BIT;
                    end
                end
            end
            grsm_pkg::ST_MUL: begin
                prod_next  = {32'd0, mul_a} * {32'd0, mul_b};
                state_next = grsm_pkg::ST_ACC;
            end
            grsm_pkg::ST_ACC: begin
                if (step_reg == 3'd0) begin
                    bound_next = prod_reg;
                end else begin
                    acc_next = acc_reg + ({64'd0, prod_reg} << acc_shift);
                end
                step_next = step_reg + 3'd1;
                if (step_reg == grsm_pkg::MUL_LAST) begin
                    target_next = acc_next[127:64];
                    state_next  = grsm_pkg::ST_IDLE;
                end else begin
                    state_next = grsm_pkg::ST_MUL;
                end
            end
            grsm_pkg::ST_BIT: begin
                if (!in_rem_reg) begin
                    if (cur_bit) begin
                        quot_next = quot_reg + 64'd1;
                    end else begin
                        // Unary run closed; the remainder width is sampled here.
                        code_w_next   = rice_clamped;
                        rem_acc_next  = '0;
                        rem_left_next = rice_clamped;
                        in_rem_next   = 1'b1;
                        finish        = (rice_clamped == 6'd0);
                    end
                end else begin
                    rem_acc_next  = {rem_acc_reg[30:0], cur_bit};
                    rem_left_next = rem_left_reg - 6'd1;
                    finish        = (rem_left_reg == 6'd1);
                end
                bit_idx_next  = bit_idx_reg - 3'd1;
                last_bit_next = (bit_idx_reg == 3'd0);
                if (finish) begin
                    state_next = grsm_pkg::ST_SUM;
                end else if (bit_idx_reg == 3'd0) begin
                    state_next = grsm_pkg::ST_IDLE;
                end
            end
            grsm_pkg::ST_SUM: begin
                // The remainder fits in code_w bits, so OR equals the add.
                running_next  = running_reg + ((quot_reg << code_w_reg) | {32'd0, rem_acc_reg});
                quot_next     = '0;
                rem_acc_next  = '0;
                rem_left_next = '0;
                in_rem_next   = 1'b0;
                state_next    = grsm_pkg::ST_CMP;
            end
            grsm_pkg::ST_CMP: begin
                decoded_next = decoded_reg + 32'd1;
                if (running_reg == target_reg) begin
                    pend_outcome_next = grsm_pkg::OUT_FOUND;
                    query_active_next = 1'b0;
                    state_next        = grsm_pkg::ST_EMIT;
                end else if (running_reg > target_reg) begin
                    pend_outcome_next = grsm_pkg::OUT_PASSED;
                    query_active_next = 1'b0;
                    state_next        = grsm_pkg::ST_EMIT;
                end else begin
                    elems_left_next = elems_left_reg - 32'd1;
                    if (elems_left_reg == 32'd1) begin
                        pend_outcome_next = grsm_pkg::OUT_EXHAUSTED;
                        query_active_next = 1'b0;
                        state_next        = grsm_pkg::ST_EMIT;
                    end else if (last_bit_reg) begin
                        state_next = grsm_pkg::ST_IDLE;
                    end else begin
                        state_next = grsm_pkg::ST_BIT;
                    end
                end
            end
            grsm_pkg::ST_EMIT: begin
                // Wait for the output register to be free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_matched_next = (pend_outcome_reg == grsm_pkg::OUT_FOUND);
                    m_outcome_next = pend_outcome_reg;
                    m_decoded_next = decoded_reg;
                    state_next     = grsm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = grsm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= grsm_pkg::ST_IDLE;
            query_active_reg <= 1'b0;
            in_rem_reg       <= 1'b0;
            step_reg         <= '0;
            m_valid_reg      <= 1'b0;
            rice_bits_reg    <= grsm_pkg::RICE_RESET;
            fp_rate_reg      <= grsm_pkg::FP_RATE_RESET;
        end else begin
            state_reg        <= state_next;
            query_active_reg <= query_active_next;
            in_rem_reg       <= in_rem_next;
            step_reg         <= step_next;
            m_valid_reg      <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    grsm_pkg::REG_RICE_BITS: rice_bits_reg <= cfg_wdata[5:0];
                    grsm_pkg::REG_FP_RATE:   fp_rate_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        hash_reg         <= hash_next;
        bound_reg        <= bound_next;
        prod_reg         <= prod_next;
        acc_reg          <= acc_next;
        target_reg       <= target_next;
        running_reg      <= running_next;
        quot_reg         <= quot_next;
        rem_acc_reg      <= rem_acc_next;
        rem_left_reg     <= rem_left_next;
        code_w_reg       <= code_w_next;
        elems_left_reg   <= elems_left_next;
        decoded_reg      <= decoded_next;
        byte_reg         <= byte_next;
        bit_idx_reg      <= bit_idx_next;
        last_bit_reg     <= last_bit_next;
        pend_outcome_reg <= pend_outcome_next;
        m_matched_reg    <= m_matched_next;
        m_outcome_reg    <= m_outcome_next;
        m_decoded_reg    <= m_decoded_next;
    end

    // A result word only appears after the emit state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == grsm_pkg::ST_EMIT)
        else $error("result issued outside the emit state");

    // The match flag agrees with the outcome code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_matched_reg == (m_outcome_reg == grsm_pkg::OUT_FOUND)))
        else $error("matched flag disagrees with outcome");

    // While decoding a remainder there is always at least one bit left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == grsm_pkg::ST_BIT && in_rem_reg) |-> rem_left_reg != 6'd0)
        else $error("remainder counter ran out while decoding");

    // A compare that moves to the emit state leaves the query closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == grsm_pkg::ST_CMP && state_next == grsm_pkg::ST_EMIT)
            |=> !query_active_reg)
        else $error("query left open after a decision");

endmodule

// ===== dv/grsm_match_checker.sv =====
// Checker for the Golomb-Rice coded set match block: watches the register port and both
// channels, predicts each result word and compares it with what the block returns.
// Depends on grsm_pkg for the op, outcome and register codes.
`timescale 1ns / 100ps

module grsm_match_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_op,
    input  logic [63:0] s_target_hash,
    input  logic [31:0] s_set_count,
    input  logic [7:0]  s_data_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_matched,
    input  logic [1:0]  m_outcome,
    input  logic [31:0] m_elements_decoded,
    output int          mismatch_count,
    output int          pending_words,
    output int          found_count,
    output int          passed_count,
    output int          exhausted_count
);

    typedef struct packed {
        logic        matched;
        logic [1:0]  outcome;
        logic [31:0] n_elems;
    } verdict_t;

    verdict_t verdict_q[$];

    // Register copies.
    logic [5:0]  rice_cfg;
    logic [31:0] rate_cfg;

    // Decoder state of the predicted query.
    logic [63:0] tgt_value;
    logic [63:0] run_sum;
    logic [63:0] q_count;
    logic [31:0] rem_acc;
    logic [5:0]  rem_left;
    logic [5:0]  width_now;
    logic        in_rem;
    logic [31:0] elems_left;
    logic [31:0] n_decoded;
    logic        busy;

    // Queues the decision and closes the query.
    task automatic post_verdict(input logic [1:0] code);
        verdict_t v;
        v.matched = (code == grsm_pkg::OUT_FOUND);
        v.outcome = code;
        v.n_elems = n_decoded;
        verdict_q.push_back(v);
        busy = 1'b0;
    endtask

    // Adds the finished delta to the running value and decides if it can.
    task automatic close_element(output logic decided);
        logic [63:0] delta;
        delta = (q_count << width_now) + {32'd0, rem_acc};
        run_sum = run_sum + delta;
        q_count = '0;
        rem_acc = '0;
        rem_left = '0;
        in_rem = 1'b0;
        n_decoded = n_decoded + 32'd1;
        decided = 1'b1;
        if (run_sum == tgt_value) begin
            post_verdict(grsm_pkg::OUT_FOUND);
        end else if (run_sum > tgt_value) begin
            post_verdict(grsm_pkg::OUT_PASSED);
        end else begin
            elems_left = elems_left - 32'd1;
            if (elems_left == 32'd0) begin
                post_verdict(grsm_pkg::OUT_EXHAUSTED);
            end else begin
                decided = 1'b0;
            end
        end
    endtask

    task automatic decode_word(input logic op, input logic [63:0] hash,
                               input logic [31:0] cnt, input logic [7:0] dbyte);
        logic [63:0]  bound;
        logic [127:0] prod;
        logic         done;
        int           i;
        done = 1'b0;
        if (op == grsm_pkg::OP_START) begin
            bound = {32'd0, rate_cfg} * {32'd0, cnt};
            prod = {64'd0, hash} * {64'd0, bound};
            tgt_value = prod[127:64];
            run_sum = '0;
            q_count = '0;
            rem_acc = '0;
            rem_left = '0;
            width_now = '0;
            in_rem = 1'b0;
            elems_left = cnt;
            n_decoded = '0;
            busy = 1'b1;
            if (cnt == 32'd0) begin
                post_verdict(grsm_pkg::OUT_EXHAUSTED);
            end
        end else if (busy) begin
            for (i = 7; i >= 0; i--) begin
                if (!done) begin
                    if (!in_rem) begin
                        if (dbyte[i]) begin
                            q_count = q_count + 64'd1;
                        end else begin
                            width_now = (rice_cfg > grsm_pkg::MAX_RICE) ? grsm_pkg::MAX_RICE
                                                                        : rice_cfg;
                            rem_acc = '0;
                            rem_left = width_now;
                            in_rem = 1'b1;
                            if (rem_left == 6'd0) begin
                                close_element(done);
                            end
                        end
                    end else begin
                        rem_acc = {rem_acc[30:0], dbyte[i]};
                        rem_left = rem_left - 6'd1;
                        if (rem_left == 6'd0) begin
                            close_element(done);
                        end
                    end
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        verdict_t want;
        if (!aresetn) begin
            rice_cfg = grsm_pkg::RICE_RESET;
            rate_cfg = grsm_pkg::FP_RATE_RESET;
            tgt_value = '0;
            run_sum = '0;
            q_count = '0;
            rem_acc = '0;
            rem_left = '0;
            width_now = '0;
            in_rem = 1'b0;
            elems_left = '0;
            n_decoded = '0;
            busy = 1'b0;
            verdict_q.delete();
        end else begin
            // The result side is checked first: a word leaving now was predicted earlier.
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result word with none expected: %s %0b %0d %0d",
                                 $realtime, "matched/outcome/elements", m_matched,
                                 m_outcome, m_elements_decoded);
                    end
                end else begin
                    want = verdict_q.pop_front();
                    if (m_matched !== want.matched || m_outcome !== want.outcome ||
                        m_elements_decoded !== want.n_elems) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: result mismatch: expected matched %0b %s %0d %s %0d",
                                     $realtime, want.matched, "outcome", want.outcome,
                                     "elements", want.n_elems);
                            $display("%0t:                  got matched %0b %s %0d %s %0d",
                                     $realtime, m_matched, "outcome", m_outcome,
                                     "elements", m_elements_decoded);
                        end
                    end
                    case (want.outcome)
                        grsm_pkg::OUT_FOUND:  found_count++;
                        grsm_pkg::OUT_PASSED: passed_count++;
                        default:              exhausted_count++;
                    endcase
                end
            end
            if (cfg_wr_en) begin
                if (cfg_addr == grsm_pkg::REG_RICE_BITS) begin
                    rice_cfg = cfg_wdata[5:0];
                end else if (cfg_addr == grsm_pkg::REG_FP_RATE) begin
                    rate_cfg = cfg_wdata;
                end
            end
            if (s_valid && s_ready) begin
                decode_word(s_op, s_target_hash, s_set_count, s_data_byte);
            end
        end
        pending_words = verdict_q.size();
    end

endmodule

// ===== dv/golomb_rice_set_member_match_tb.sv =====
// Testbench top for the Golomb-Rice coded set match block: clock, reset, register setup,
// encoded-set stimulus, receiver stalls, watchdog and the final verdict.
// Depends on grsm_pkg, the block itself and grsm_match_checker.
`timescale 1ns / 100ps

module golomb_rice_set_member_match_tb;

    // A word moves on some port at least this often, or the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Cycles allowed for a byte or start word still in flight to finish.
    localparam int SETTLE_CYCLES  = 48;
    // Length of the receiver hold-off that fills the block up.
    localparam int HOLD_LEN       = 800;
    localparam int PHASE_WORDS    = 130;
    localparam int N_PHASES       = 12;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr  = grsm_pkg::REG_RICE_BITS;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic        s_op      = grsm_pkg::OP_BYTE;
    logic [63:0] s_target_hash = '0;
    logic [31:0] s_set_count   = '0;
    logic [7:0]  s_data_byte   = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic        m_matched;
    logic [1:0]  m_outcome;
    logic [31:0] m_elements_decoded;

    int mismatch_count;
    int pending_words;
    int found_count;
    int passed_count;
    int exhausted_count;

    // Sender pacing and bookkeeping.
    int burst_left     = 0;
    bit pacing_on      = 1'b1;
    int words_sent     = 0;
    int starts_sent    = 0;
    int settings_used  = 0;

    // Register values the stimulus generator believes are loaded.
    logic [5:0]  cur_rice = grsm_pkg::RICE_RESET;
    logic [31:0] cur_rate = grsm_pkg::FP_RATE_RESET;

    // Scratch space for building one coded set.
    bit          code_bits [0:8191];
    int          n_bits;
    logic [63:0] set_vals [0:63];

    // Receiver pattern state.
    bit hold_req   = 1'b0;
    int hold_left  = 0;
    int rx_cycle   = 0;
    int stall_pct  = 0;
    int idle_cycles = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    golomb_rice_set_member_match uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_target_hash      (s_target_hash),
        .s_set_count        (s_set_count),
        .s_data_byte        (s_data_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_outcome          (m_outcome),
        .m_elements_decoded (m_elements_decoded)
    );

    grsm_match_checker chk (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_op               (s_op),
        .s_target_hash      (s_target_hash),
        .s_set_count        (s_set_count),
        .s_data_byte        (s_data_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_outcome          (m_outcome),
        .m_elements_decoded (m_elements_decoded),
        .mismatch_count     (mismatch_count),
        .pending_words      (pending_words),
        .found_count        (found_count),
        .passed_count       (passed_count),
        .exhausted_count    (exhausted_count)
    );

    // Receiver. It changes its stall rate over the run, from never stalling to
    // stalling most of the time. When the stimulus asks for a hold-off, ready stays
    // low while hold_left counts the hold-off down, and the sender keeps offering words.
    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 256 == 0) begin
            case ($urandom_range(3, 0))
                0:       stall_pct = 0;
                1:       stall_pct = 25;
                2:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_LEN - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Offers one word and returns at the edge where it is taken. Words go out in
    // bursts of random length; while pacing is on, valid may drop between bursts for a random gap.
    task automatic offer_word(input logic op, input logic [63:0] hash,
                              input logic [31:0] cnt, input logic [7:0] dbyte);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap = pacing_on ? $urandom_range(10, 0) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_op          <= op;
        s_target_hash <= hash;
        s_set_count   <= cnt;
        s_data_byte   <= dbyte;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (op == grsm_pkg::OP_START) begin
            starts_sent++;
        end
    endtask

    // Lets every predicted result drain, then gives a byte that can cause no result
    // time to finish inside the block, so that the next register write sees it idle.
    task automatic quiesce;
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending_words == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_registers(input logic [5:0] rice, input logic [31:0] rate);
        logic [31:0] wd;
        quiesce();
        // Bits above the register width carry noise; only the low six count.
        wd = $urandom();
        wd[5:0] = rice;
        cfg_wr_en <= 1'b1;
        cfg_addr  <= grsm_pkg::REG_RICE_BITS;
        cfg_wdata <= wd;
        @(posedge aclk);
        cfg_addr  <= grsm_pkg::REG_FP_RATE;
        cfg_wdata <= rate;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_rice = rice;
        cur_rate = rate;
        settings_used++;
    endtask

    // Upper half of the 128-bit product: maps a hash into [0, bound).
    function automatic logic [63:0] scale_hash(input logic [63:0] h, input logic [63:0] bound);
        logic [127:0] prod;
        prod = {64'd0, h} * {64'd0, bound};
        return prod[127:64];
    endfunction

    // Builds and sends a coded set the way a real filter is made: element hashes are
    // mapped into the range, sorted, and written as unary quotient plus remainder.
    // With plant set, the target's own value is one of the elements, so the query
    // should end on a match. The set count sent may differ from the number coded,
    // and the stream may be cut short, which leaves the query open for the next
    // start to drop. Random bytes may follow the coded set; the block ignores them
    // once it has decided.
    task automatic send_coded_set(input int n_elem, input logic [31:0] claimed,
                                  input bit plant, input bit truncate);
        logic [63:0] hash;
        logic [63:0] bound;
        logic [63:0] target;
        logic [63:0] v;
        logic [63:0] prev;
        logic [63:0] delta;
        logic [63:0] quo;
        logic [7:0]  b;
        int          width;
        int          i;
        int          j;
        int          k;
        int          n_bytes;
        hash   = {$urandom(), $urandom()};
        bound  = {32'd0, cur_rate} * {32'd0, claimed};
        target = scale_hash(hash, bound);
        width  = (cur_rice > grsm_pkg::MAX_RICE) ? grsm_pkg::MAX_RICE : cur_rice;

        // Insertion sort of the element values.
        for (i = 0; i < n_elem; i++) begin
            v = (plant && i == 0) ? target : scale_hash({$urandom(), $urandom()}, bound);
            j = i;
            while (j > 0 && set_vals[j - 1] > v) begin
                set_vals[j] = set_vals[j - 1];
                j--;
            end
            set_vals[j] = v;
        end

        n_bits = 0;
        prev = '0;
        for (i = 0; i < n_elem; i++) begin
            delta = set_vals[i] - prev;
            prev = set_vals[i];
            quo = delta >> width;
            for (k = 0; k < quo; k++) begin
                code_bits[n_bits] = 1'b1;
                n_bits++;
            end
            code_bits[n_bits] = 1'b0;
            n_bits++;
            for (k = width - 1; k >= 0; k--) begin
                code_bits[n_bits] = delta[k];
                n_bits++;
            end
        end
        // Pad to a whole byte and add up to two bytes of trailing noise.
        k = 8 * $urandom_range(2, 0);
        while (n_bits % 8 != 0 || k > 0) begin
            code_bits[n_bits] = ($urandom_range(1, 0) == 1);
            n_bits++;
            if (n_bits % 8 == 0 && k > 0) begin
                k -= 8;
            end
        end
        n_bytes = n_bits / 8;
        if (truncate && n_bytes > 1) begin
            n_bytes = $urandom_range(n_bytes - 1, 1);
        end

        offer_word(grsm_pkg::OP_START, hash, claimed, 8'($urandom_range(255, 0)));
        for (i = 0; i < n_bytes; i++) begin
            for (j = 0; j < 8; j++) begin
                b[7 - j] = code_bits[8 * i + j];
            end
            offer_word(grsm_pkg::OP_BYTE, {$urandom(), $urandom()}, $urandom(), b);
        end
    endtask

    // A start with arbitrary hash and count followed by random bytes, which decode
    // to whatever they happen to mean. An empty set turns the bytes into ignored ones.
    task automatic send_noise(input bit empty_set);
        logic [31:0] cnt;
        int          n;
        int          i;
        if (empty_set) begin
            cnt = '0;
            n = $urandom_range(2, 0);
        end else begin
            cnt = $urandom_range(1, 0) ? $urandom() : $urandom_range(4, 1);
            n = $urandom_range(6, 1);
        end
        offer_word(grsm_pkg::OP_START, {$urandom(), $urandom()}, cnt,
                   8'($urandom_range(255, 0)));
        for (i = 0; i < n; i++) begin
            offer_word(grsm_pkg::OP_BYTE, {$urandom(), $urandom()}, $urandom(),
                       8'($urandom_range(255, 0)));
        end
    endtask

    initial begin
        logic [5:0]  rice;
        logic [31:0] rate;
        int          p;
        int          w;
        int          n;
        int          r;
        int          phase_base;
        bit          held;
        bit          plant_now;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, at the reset register values (19 remainder bits, rate 784931).
        // Bytes before any start are taken and ignored.
        offer_word(grsm_pkg::OP_BYTE, '1, '1, 8'hFF);
        offer_word(grsm_pkg::OP_BYTE, '0, '0, 8'h00);
        // Empty set: answers at once with set exhausted and zero elements.
        offer_word(grsm_pkg::OP_START, '0, '0, 8'h5A);
        offer_word(grsm_pkg::OP_BYTE, '0, '0, 8'hA5);
        // Largest hash and count; two bytes of one unary run, then a new start drops the query.
        offer_word(grsm_pkg::OP_START, '1, '1, 8'hFF);
        offer_word(grsm_pkg::OP_BYTE, '1, '1, 8'hFF);
        offer_word(grsm_pkg::OP_BYTE, '1, '1, 8'hFF);
        // Target value zero: one element of delta zero matches inside the third byte,
        // and the rest of that byte and the next byte are dropped.
        offer_word(grsm_pkg::OP_START, '0, 32'd1, 8'h00);
        offer_word(grsm_pkg::OP_BYTE, '0, '0, 8'h00);
        offer_word(grsm_pkg::OP_BYTE, '0, '0, 8'h00);
        offer_word(grsm_pkg::OP_BYTE, '0, '0, 8'h0F);
        offer_word(grsm_pkg::OP_BYTE, '0, '0, 8'hFF);
        // Target 392465: a first delta of 2^20 - 1 passes it.
        offer_word(grsm_pkg::OP_START, 64'h8000_0000_0000_0000, 32'd1, 8'h00);
        offer_word(grsm_pkg::OP_BYTE, '0, '0, 8'hBF);
        offer_word(grsm_pkg::OP_BYTE, '0, '0, 8'hFF);
        offer_word(grsm_pkg::OP_BYTE, '0, '0, 8'hFF);
        // Two zero deltas stay below the target, so the set runs out after two.
        offer_word(grsm_pkg::OP_START, '1, 32'd2, 8'h00);
        repeat (5) offer_word(grsm_pkg::OP_BYTE, '1, '1, 8'h00);

        // Random part. Each phase loads a register setting; remainder widths run from
        // zero through 32 and above, with the rate chosen so quotients stay short,
        // plus a zero rate that puts every value at zero.
        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0:  begin rice = 6'd19; rate = 32'd784931;      end
                1:  begin rice = 6'd0;  rate = 32'd1;           end
                2:  begin rice = 6'd1;  rate = 32'd2;           end
                3:  begin rice = 6'd32; rate = 32'hFFFF_FFFF;   end
                4:  begin rice = 6'd63; rate = 32'hFFFF_FFFF;   end
                5:  begin rice = 6'd5;  rate = 32'd40;          end
                7:  begin rice = 6'd10; rate = 32'd1500;        end
                8:  begin rice = 6'd24; rate = 32'd20000000;    end
                10: begin rice = 6'd7;  rate = 32'd0;           end
                11: begin rice = 6'd33; rate = 32'h9000_0000;   end
                default: begin
                    w = $urandom_range(30, 2);
                    rice = 6'(w);
                    rate = $urandom_range((32'd1 << (w + 1)) - 1, 32'd1 << (w - 1));
                end
            endcase
            load_registers(rice, rate);
            // Every fourth phase the sender never pauses.
            pacing_on = (p % 4 != 3);
            phase_base = words_sent;
            held = 1'b0;
            while (words_sent - phase_base < PHASE_WORDS) begin
                // Twice in the run the receiver holds off while words keep coming.
                if ((p == 2 || p == 7) && !held && words_sent - phase_base >= 40) begin
                    hold_req = 1'b1;
                    held = 1'b1;
                end
                n = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13)
                                                : $urandom_range(12, 1);
                r = $urandom_range(99, 0);
                plant_now = ($urandom_range(1, 0) == 1);
                if (r < 60) begin
                    send_coded_set(n, n, plant_now, 1'b0);
                end else if (r < 70) begin
                    send_coded_set(n, n + $urandom_range(3, 1), plant_now, 1'b0);
                end else if (r < 78) begin
                    send_coded_set(n, $urandom_range(n, 1), plant_now, 1'b0);
                end else if (r < 86) begin
                    send_coded_set(n, n, plant_now, 1'b1);
                end else if (r < 90) begin
                    send_noise(1'b1);
                end else begin
                    send_noise(1'b0);
                end
            end
        end

        quiesce();

        $display("Run covered %0d input words (%0d starts) over %0d %s",
                 words_sent, starts_sent, settings_used,
                 "register settings plus reset values.");
        $display("Results checked: %0d found, %0d passed the target, %0d set exhausted.",
                 found_count, passed_count, exhausted_count);
        if (pending_words != 0) begin
            $display("%0d expected result words never arrived", pending_words);
        end
        if (mismatch_count == 0 && pending_words == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/grsm_pkg.sv
rtl/golomb_rice_set_member_match.sv
dv/grsm_match_checker.sv
dv/golomb_rice_set_member_match_tb.sv
